// ===== src/assert_macros.svh =====
// Assertion helpers shared by the queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== src/tcpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tcpq_pkg
// Sizes, codes and control types for the two-class priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpq_pkg;

	localparam int PRIORITY_DEPTH = 16;
	localparam int FIFO_DEPTH     = 16;
	localparam int MAX_RESULTS    = 32;

	localparam int REQ_W     = 2;
	localparam int TAG_W     = 16;
	localparam int SEV_W     = 4;
	localparam int STATUS_W  = 3;
	localparam int WAIT_W    = 11;
	localparam int CONSULT_W = 6;

	localparam int PIDX_W = (PRIORITY_DEPTH > 1) ? $clog2(PRIORITY_DEPTH) : 1;
	localparam int FIDX_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int PCNT_W = $clog2(PRIORITY_DEPTH + 1);
	localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int TOT_W  = $clog2(PRIORITY_DEPTH + FIFO_DEPTH + 1);
	localparam int K_W    = $clog2(MAX_RESULTS);
	localparam int NCNT_W = $clog2(MAX_RESULTS + 1);
	localparam int CMP_W  = (TOT_W > NCNT_W) ? TOT_W : NCNT_W;

	localparam logic [CONSULT_W-1:0] CONSULT_RESET = CONSULT_W'(10);

	typedef enum logic [REQ_W-1:0] {
		REQ_ADD_REG  = 2'd0,
		REQ_ADD_EMER = 2'd1,
		REQ_SERVE    = 2'd2,
		REQ_LIST     = 2'd3
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ADDED  = 3'd0,
		ST_SERVED = 3'd1,
		ST_EMPTY  = 3'd2,
		ST_FULL   = 3'd3,
		ST_LIST   = 3'd4,
		ST_NONE   = 3'd5
	} status_t;

	typedef struct packed {
		logic load;
		logic emit;
	} ctl_cmd_t;

	typedef struct packed {
		logic last;
	} ctl_stat_t;

endpackage

`default_nettype wire

// ===== src/two_class_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// two_class_priority_queue_core
// Strict priority queue (sorted by severity) over a plain FIFO class.
// ----------------------------------------------------------------------------
// Requests: drive req_type/patient_tag/severity with start; the transfer
// happens on a clock edge where start is high and busy is low.
// req_type: add regular, add emergency, serve next, list waits.
// Results: one per add/serve, one per waiting entry for a list (or one
// "none waiting"). Each result is shown for one cycle with out_valid high;
// last marks the final result of a request. The receiver cannot stall.
// Timing: the request is latched on the transfer edge, then the sequencer
// passes through a fetch state (registered FIFO RAM read) and an emit
// state that loads the result register, one fetch/emit pair per result.
// A new request is taken on the edge that emits the final result of the
// previous one.
// Config: cfg_data (consult minutes) is written when cfg_valid and
// cfg_ready are high; cfg_ready is always high. Write only while idle.
// Reset (arst_n low): both stores empty, consult minutes = 10, no result.
// ----------------------------------------------------------------------------
`default_nettype none

module two_class_priority_queue_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [tcpq_pkg::REQ_W-1:0]        req_type,
	input  wire logic [tcpq_pkg::TAG_W-1:0]        patient_tag,
	input  wire logic [tcpq_pkg::SEV_W-1:0]        severity,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [tcpq_pkg::CONSULT_W-1:0]    cfg_data,
	output logic                                   out_valid,
	output logic [tcpq_pkg::STATUS_W-1:0]          status,
	output logic [tcpq_pkg::TAG_W-1:0]             out_tag,
	output logic                                   is_emergency,
	output logic [tcpq_pkg::SEV_W-1:0]             out_severity,
	output logic [tcpq_pkg::WAIT_W-1:0]            wait_minutes,
	output logic                                   last
);
	import tcpq_pkg::*;

	ctl_cmd_t  cmd;
	ctl_stat_t stat;

	assign cfg_ready = 1'b1;

	tcpq_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.stat  (stat)
	);

	tcpq_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.req_type    (req_type),
		.patient_tag (patient_tag),
		.severity    (severity),
		.cfg_wr      (cfg_valid & cfg_ready),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.status      (status),
		.out_tag     (out_tag),
		.is_emergency(is_emergency),
		.out_severity(out_severity),
		.wait_minutes(wait_minutes),
		.last        (last)
	);

endmodule

`default_nettype wire

// ===== src/tcpq_ram.sv =====
// ----------------------------------------------------------------------------
// tcpq_ram
// Generic simple dual-port RAM, one write port, registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== src/tcpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcpq_ctrl
// Request sequencer: fetch / emit loop per result, overlaps next request.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tcpq_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	output tcpq_pkg::ctl_cmd_t      cmd,
	input  wire tcpq_pkg::ctl_stat_t stat
);
	import tcpq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_FETCH = 3'b010,
		S_EMIT  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_FETCH;
				end
			end
			S_FETCH: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				if (!stat.last) begin
					state_d = S_FETCH;
				end else begin
					busy = 1'b0;
					if (start) begin
						cmd.load = 1'b1;
						state_d  = S_FETCH;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`ASSERT_NEXT(a_fetch_then_emit, clk, arst_n, state_q == S_FETCH, state_q == S_EMIT)
	`ASSERT_NEXT(a_list_continues, clk, arst_n, (state_q == S_EMIT) && !stat.last, state_q == S_FETCH)

endmodule

`default_nettype wire

// ===== src/tcpq_dp.sv =====
// ----------------------------------------------------------------------------
// tcpq_dp
// Queue datapath: sorted priority registers, FIFO RAM, result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tcpq_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire tcpq_pkg::ctl_cmd_t                cmd,
	output tcpq_pkg::ctl_stat_t                    stat,
	input  wire logic [tcpq_pkg::REQ_W-1:0]        req_type,
	input  wire logic [tcpq_pkg::TAG_W-1:0]        patient_tag,
	input  wire logic [tcpq_pkg::SEV_W-1:0]        severity,
	input  wire logic                              cfg_wr,
	input  wire logic [tcpq_pkg::CONSULT_W-1:0]    cfg_data,
	output logic                                   out_valid,
	output logic [tcpq_pkg::STATUS_W-1:0]          status,
	output logic [tcpq_pkg::TAG_W-1:0]             out_tag,
	output logic                                   is_emergency,
	output logic [tcpq_pkg::SEV_W-1:0]             out_severity,
	output logic [tcpq_pkg::WAIT_W-1:0]            wait_minutes,
	output logic                                   last
);
	import tcpq_pkg::*;

	// request latch
	req_t                 req_q;
	logic [TAG_W-1:0]     tag_in_q;
	logic [SEV_W-1:0]     sev_in_q;
	logic [K_W-1:0]       k_q;
	logic [WAIT_W-1:0]    wait_q;
	logic [CONSULT_W-1:0] consult_q;

	// stores
	logic [TAG_W-1:0]  pri_tag_q [PRIORITY_DEPTH];
	logic [SEV_W-1:0]  pri_sev_q [PRIORITY_DEPTH];
	logic [PCNT_W-1:0] pcount_q;
	logic [FIDX_W-1:0] head_q;
	logic [FIDX_W-1:0] tail_q;
	logic [FCNT_W-1:0] fcount_q;

	// result register
	logic                out_valid_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [TAG_W-1:0]    res_tag_q;
	logic                res_emer_q;
	logic [SEV_W-1:0]    res_sev_q;
	logic [WAIT_W-1:0]   res_wait_q;
	logic                res_last_q;

	logic [PRIORITY_DEPTH-1:0] ge;
	logic [PRIORITY_DEPTH-1:0] prev_ge;
	logic                      pri_full;
	logic                      fifo_full;
	logic [CMP_W-1:0]          list_n;
	logic [CMP_W-1:0]          fifo_off;
	logic [FIDX_W:0]           raddr_sum;
	logic [FIDX_W-1:0]         raddr;
	logic [TAG_W-1:0]          fifo_rdata;
	logic [FIDX_W:0]           tail_sum;
	logic [FIDX_W-1:0]         tail_chk;
	logic [PIDX_W-1:0]         k_idx;
	logic                      k_in_pri;
	logic                      do_push;
	logic                      do_insert;
	logic                      do_pop_pri;
	logic                      do_pop_fifo;

	status_t          r_status;
	logic [TAG_W-1:0] r_tag;
	logic             r_emer;
	logic [SEV_W-1:0] r_sev;
	logic [WAIT_W-1:0] r_wait;
	logic             r_last;

	assign pri_full  = (pcount_q == PCNT_W'(PRIORITY_DEPTH));
	assign fifo_full = (fcount_q == FCNT_W'(FIFO_DEPTH));
	assign k_idx     = k_q[PIDX_W-1:0];
	assign k_in_pri  = (CMP_W'(k_q) < CMP_W'(pcount_q));

	always_comb begin
		list_n = CMP_W'(pcount_q) + CMP_W'(fcount_q);
		if (list_n > CMP_W'(MAX_RESULTS)) begin
			list_n = CMP_W'(MAX_RESULTS);
		end
	end

	// FIFO read address: head for serve, head + offset for list
	always_comb begin
		fifo_off  = k_in_pri ? '0 : (CMP_W'(k_q) - CMP_W'(pcount_q));
		raddr_sum = (FIDX_W+1)'(head_q) + (FIDX_W+1)'(fifo_off[FIDX_W-1:0]);
		if (raddr_sum >= (FIDX_W+1)'(FIFO_DEPTH)) begin
			raddr_sum = raddr_sum - (FIDX_W+1)'(FIFO_DEPTH);
		end
		raddr = raddr_sum[FIDX_W-1:0];
	end

	always_comb begin
		tail_sum = (FIDX_W+1)'(head_q) + (FIDX_W+1)'(fcount_q);
		if (tail_sum >= (FIDX_W+1)'(FIFO_DEPTH)) begin
			tail_sum = tail_sum - (FIDX_W+1)'(FIFO_DEPTH);
		end
		tail_chk = tail_sum[FIDX_W-1:0];
	end

	// sorted insert: new entry goes after every entry of equal or higher severity
	always_comb begin
		for (int i = 0; i < PRIORITY_DEPTH; i++) begin
			ge[i] = (i < int'(pcount_q)) && (pri_sev_q[i] >= sev_in_q);
		end
		prev_ge[0] = 1'b1;
		for (int i = 1; i < PRIORITY_DEPTH; i++) begin
			prev_ge[i] = ge[i-1];
		end
	end

	tcpq_ram #(
		.WIDTH(TAG_W),
		.DEPTH(FIFO_DEPTH)
	) u_fifo_ram (
		.clk  (clk),
		.we   (do_push),
		.waddr(tail_q),
		.wdata(tag_in_q),
		.raddr(raddr),
		.rdata(fifo_rdata)
	);

	always_comb begin
		r_status    = ST_ADDED;
		r_tag       = '0;
		r_emer      = 1'b0;
		r_sev       = '0;
		r_wait      = '0;
		r_last      = 1'b1;
		do_push     = 1'b0;
		do_insert   = 1'b0;
		do_pop_pri  = 1'b0;
		do_pop_fifo = 1'b0;
		case (req_q)
			REQ_ADD_REG: begin
				if (fifo_full) begin
					r_status = ST_FULL;
				end else begin
					do_push = cmd.emit;
				end
			end
			REQ_ADD_EMER: begin
				if (pri_full) begin
					r_status = ST_FULL;
				end else begin
					do_insert = cmd.emit;
				end
			end
			REQ_SERVE: begin
				if (pcount_q != '0) begin
					r_status   = ST_SERVED;
					r_tag      = pri_tag_q[0];
					r_emer     = 1'b1;
					r_sev      = pri_sev_q[0];
					do_pop_pri = cmd.emit;
				end else if (fcount_q != '0) begin
					r_status    = ST_SERVED;
					r_tag       = fifo_rdata;
					do_pop_fifo = cmd.emit;
				end else begin
					r_status = ST_EMPTY;
				end
			end
			REQ_LIST: begin
				if (list_n == '0) begin
					r_status = ST_NONE;
				end else begin
					r_status = ST_LIST;
					r_wait   = wait_q;
					r_last   = ((CMP_W'(k_q) + CMP_W'(1)) == list_n);
					if (k_in_pri) begin
						r_tag  = pri_tag_q[k_idx];
						r_emer = 1'b1;
						r_sev  = pri_sev_q[k_idx];
					end else begin
						r_tag = fifo_rdata;
					end
				end
			end
			default: begin
				r_status = ST_NONE;
			end
		endcase
	end

	assign stat.last = r_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			consult_q   <= CONSULT_RESET;
			pcount_q    <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			fcount_q    <= '0;
			out_valid_q <= 1'b0;
			req_q       <= REQ_ADD_REG;
			k_q         <= '0;
			wait_q      <= '0;
		end else begin
			if (cfg_wr) begin
				consult_q <= cfg_data;
			end
			out_valid_q <= cmd.emit;
			if (cmd.load) begin
				req_q  <= req_t'(req_type);
				k_q    <= '0;
				wait_q <= '0;
			end else if (cmd.emit) begin
				k_q    <= K_W'(k_q + K_W'(1));
				wait_q <= WAIT_W'(wait_q + WAIT_W'(consult_q));
			end
			if (do_push) begin
				tail_q   <= (tail_q == FIDX_W'(FIFO_DEPTH - 1)) ? '0 : FIDX_W'(tail_q + 1'b1);
				fcount_q <= FCNT_W'(fcount_q + 1'b1);
			end
			if (do_pop_fifo) begin
				head_q   <= (head_q == FIDX_W'(FIFO_DEPTH - 1)) ? '0 : FIDX_W'(head_q + 1'b1);
				fcount_q <= FCNT_W'(fcount_q - 1'b1);
			end
			if (do_insert) begin
				pcount_q <= PCNT_W'(pcount_q + 1'b1);
			end
			if (do_pop_pri) begin
				pcount_q <= PCNT_W'(pcount_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tag_in_q <= patient_tag;
			sev_in_q <= severity;
		end
		if (do_insert) begin
			for (int i = 0; i < PRIORITY_DEPTH; i++) begin
				if (!ge[i]) begin
					if (prev_ge[i]) begin
						pri_tag_q[i] <= tag_in_q;
						pri_sev_q[i] <= sev_in_q;
					end else begin
						pri_tag_q[i] <= pri_tag_q[(i > 0) ? i - 1 : 0];
						pri_sev_q[i] <= pri_sev_q[(i > 0) ? i - 1 : 0];
					end
				end
			end
		end else if (do_pop_pri) begin
			for (int i = 0; i < PRIORITY_DEPTH - 1; i++) begin
				pri_tag_q[i] <= pri_tag_q[i+1];
				pri_sev_q[i] <= pri_sev_q[i+1];
			end
		end
		if (cmd.emit) begin
			res_status_q <= r_status;
			res_tag_q    <= r_tag;
			res_emer_q   <= r_emer;
			res_sev_q    <= r_sev;
			res_wait_q   <= r_wait;
			res_last_q   <= r_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = res_status_q;
	assign out_tag      = res_tag_q;
	assign is_emergency = res_emer_q;
	assign out_severity = res_sev_q;
	assign wait_minutes = res_wait_q;
	assign last         = res_last_q;

	`ASSERT_IMPL(a_pcount_range, clk, arst_n, 1'b1, pcount_q <= PCNT_W'(PRIORITY_DEPTH))
	`ASSERT_IMPL(a_fifo_ptrs, clk, arst_n, 1'b1, tail_chk == tail_q)
	`ASSERT_NEXT(a_emit_strobe, clk, arst_n, cmd.emit, out_valid_q)
	`ASSERT_IMPL(a_fifo_no_sev, clk, arst_n, out_valid_q && !res_emer_q, res_sev_q == '0)

endmodule

`default_nettype wire

// ===== verif/two_class_priority_queue_core_test.sv =====
// ----------------------------------------------------------------------------
// two_class_priority_queue_core_test
// Self-checking bench for the two-class priority queue. Requests are sent
// through the start/busy handshake and a model of both stores predicts every
// result. Each strobed result is compared field by field with the oldest
// prediction. The consult interval is changed between phases while the block
// is idle, including zero and the top of its range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_class_priority_queue_core_test;
	import tcpq_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		status_t             status;
		logic [TAG_W-1:0]    tag;
		logic                emer;
		logic [SEV_W-1:0]    sev;
		logic [WAIT_W-1:0]   wait_min;
		logic                last;
	} outcome_t;

	class waiting_room;
		logic [TAG_W-1:0]     pri_tag[PRIORITY_DEPTH];
		logic [SEV_W-1:0]     pri_sev[PRIORITY_DEPTH];
		int unsigned          pri_count;
		logic [TAG_W-1:0]     fifo_tag[FIFO_DEPTH];
		int unsigned          fifo_head;
		int unsigned          fifo_tail;
		int unsigned          fifo_count;
		logic [CONSULT_W-1:0] consult_min;
		outcome_t             due[$];
		int unsigned          mismatches;

		function new();
			pri_count   = 0;
			fifo_head   = 0;
			fifo_tail   = 0;
			fifo_count  = 0;
			consult_min = CONSULT_RESET;
			mismatches  = 0;
		endfunction

		function void queue_outcome(status_t st, logic [TAG_W-1:0] tag, logic emer,
				logic [SEV_W-1:0] sev, logic [WAIT_W-1:0] w, logic last);
			outcome_t o;
			o.status   = st;
			o.tag      = tag;
			o.emer     = emer;
			o.sev      = sev;
			o.wait_min = w;
			o.last     = last;
			due.push_back(o);
		endfunction

		function void admit_request(req_t req, logic [TAG_W-1:0] tag, logic [SEV_W-1:0] sev);
			int unsigned pos;
			int unsigned n;
			int unsigned idx;
			case (req)
				REQ_ADD_REG: begin
					if (fifo_count >= FIFO_DEPTH) begin
						queue_outcome(ST_FULL, 0, 0, 0, 0, 1);
					end else begin
						fifo_tag[fifo_tail] = tag;
						fifo_tail = (fifo_tail + 1) % FIFO_DEPTH;
						fifo_count++;
						queue_outcome(ST_ADDED, 0, 0, 0, 0, 1);
					end
				end
				REQ_ADD_EMER: begin
					if (pri_count >= PRIORITY_DEPTH) begin
						queue_outcome(ST_FULL, 0, 0, 0, 0, 1);
					end else begin
						// equal severity keeps arrival order
						pos = 0;
						while (pos < pri_count && pri_sev[pos] >= sev)
							pos++;
						for (int i = pri_count; i > pos; i--) begin
							pri_tag[i] = pri_tag[i-1];
							pri_sev[i] = pri_sev[i-1];
						end
						pri_tag[pos] = tag;
						pri_sev[pos] = sev;
						pri_count++;
						queue_outcome(ST_ADDED, 0, 0, 0, 0, 1);
					end
				end
				REQ_SERVE: begin
					if (pri_count > 0) begin
						queue_outcome(ST_SERVED, pri_tag[0], 1, pri_sev[0], 0, 1);
						for (int i = 1; i < pri_count; i++) begin
							pri_tag[i-1] = pri_tag[i];
							pri_sev[i-1] = pri_sev[i];
						end
						pri_count--;
					end else if (fifo_count > 0) begin
						queue_outcome(ST_SERVED, fifo_tag[fifo_head], 0, 0, 0, 1);
						fifo_head = (fifo_head + 1) % FIFO_DEPTH;
						fifo_count--;
					end else begin
						queue_outcome(ST_EMPTY, 0, 0, 0, 0, 1);
					end
				end
				default: begin
					n = pri_count + fifo_count;
					if (n > MAX_RESULTS)
						n = MAX_RESULTS;
					if (n == 0)
						queue_outcome(ST_NONE, 0, 0, 0, 0, 1);
					for (int unsigned k = 0; k < n; k++) begin
						if (k < pri_count) begin
							queue_outcome(ST_LIST, pri_tag[k], 1, pri_sev[k],
								WAIT_W'(k * consult_min), k + 1 == n);
						end else begin
							idx = (fifo_head + k - pri_count) % FIFO_DEPTH;
							queue_outcome(ST_LIST, fifo_tag[idx], 0, 0,
								WAIT_W'(k * consult_min), k + 1 == n);
						end
					end
				end
			endcase
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_outcome(outcome_t got);
			outcome_t want;
			if (due.size() == 0) begin
				$display("%0t: unexpected result: status %0d tag %0d", $time,
					got.status, got.tag);
				mismatches++;
				return;
			end
			want = due.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("out_tag", want.tag, got.tag);
			compare_field("is_emergency", want.emer, got.emer);
			compare_field("out_severity", want.sev, got.sev);
			compare_field("wait_minutes", want.wait_min, got.wait_min);
			compare_field("last", want.last, got.last);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	req_t                  req_type = REQ_ADD_REG;
	logic [TAG_W-1:0]      patient_tag = '0;
	logic [SEV_W-1:0]      severity = '0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CONSULT_W-1:0]  cfg_data = '0;
	logic                  out_valid;
	logic [STATUS_W-1:0]   status;
	logic [TAG_W-1:0]      out_tag;
	logic                  is_emergency;
	logic [SEV_W-1:0]      out_severity;
	logic [WAIT_W-1:0]     wait_minutes;
	logic                  last;

	waiting_room room = new();
	int unsigned cycle_count = 0;

	two_class_priority_queue_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.patient_tag  (patient_tag),
		.severity     (severity),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.status       (status),
		.out_tag      (out_tag),
		.is_emergency (is_emergency),
		.out_severity (out_severity),
		.wait_minutes (wait_minutes),
		.last         (last)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		outcome_t got;
		if (arst_n && out_valid === 1'b1) begin
			got.status   = status_t'(status);
			got.tag      = out_tag;
			got.emer     = is_emergency;
			got.sev      = out_severity;
			got.wait_min = wait_minutes;
			got.last     = last;
			room.check_outcome(got);
		end
	end

	task automatic send_request(req_t r, logic [TAG_W-1:0] tag, logic [SEV_W-1:0] sev);
		@(negedge clk);
		req_type    = r;
		patient_tag = tag;
		severity    = sev;
		start       = 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		room.admit_request(r, tag, sev);
	endtask

	task automatic idle_gap(int n);
		repeat (n) begin
			@(negedge clk);
			start       = 1'b0;
			req_type    = req_t'($urandom_range(0, 3));
			patient_tag = TAG_W'($urandom);
			severity    = SEV_W'($urandom);
		end
	endtask

	task automatic settle();
		@(negedge clk);
		start = 1'b0;
		while (room.due.size() != 0 || busy !== 1'b0)
			@(posedge clk);
	endtask

	task automatic write_consult(logic [CONSULT_W-1:0] v);
		settle();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = v;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		room.consult_min = v;
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_data  = CONSULT_W'($urandom);
	endtask

	task automatic random_request(int w_reg, int w_emer, int w_serve, bit steady);
		int   roll;
		req_t r;
		logic [SEV_W-1:0] sev;
		roll = $urandom_range(0, 99);
		if (roll < w_reg)
			r = REQ_ADD_REG;
		else if (roll < w_reg + w_emer)
			r = REQ_ADD_EMER;
		else if (roll < w_reg + w_emer + w_serve)
			r = REQ_SERVE;
		else
			r = REQ_LIST;
		// a narrow band now and then to force equal severities
		if ($urandom_range(0, 3) == 0)
			sev = SEV_W'($urandom_range(6, 8));
		else
			sev = SEV_W'($urandom_range(0, 15));
		if (!steady && $urandom_range(0, 99) < 14)
			idle_gap($urandom_range(1, 4));
		send_request(r, TAG_W'($urandom), sev);
	endtask

	task automatic run_phase(int count, int w_reg, int w_emer, int w_serve, bit steady);
		repeat (count)
			random_request(w_reg, w_emer, w_serve, steady);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty stores, field extremes, severity ties, default interval
		send_request(REQ_LIST, 16'h1111, 4'h3);
		send_request(REQ_SERVE, 16'h2222, 4'h0);
		send_request(REQ_ADD_REG, 16'h0000, 4'hF);
		send_request(REQ_ADD_REG, 16'hFFFF, 4'h0);
		send_request(REQ_ADD_EMER, 16'h5555, 4'h0);
		send_request(REQ_ADD_EMER, 16'hFFFF, 4'hF);
		send_request(REQ_ADD_EMER, 16'h0000, 4'hF);
		send_request(REQ_ADD_EMER, 16'hAAAA, 4'h7);
		send_request(REQ_ADD_EMER, 16'h1234, 4'h0);
		send_request(REQ_ADD_REG, 16'hAAAA, 4'h5);
		send_request(REQ_LIST, 16'h0000, 4'h0);
		send_request(REQ_SERVE, 16'h0000, 4'h0);
		send_request(REQ_SERVE, 16'hFFFF, 4'hF);
		send_request(REQ_SERVE, 16'h0000, 4'h0);
		send_request(REQ_LIST, 16'hFFFF, 4'hF);
		repeat (6)
			send_request(REQ_SERVE, 16'h0000, 4'h0);
		send_request(REQ_SERVE, 16'h0000, 4'h0);
		send_request(REQ_LIST, 16'h0000, 4'h0);

		write_consult(6'd1);
		run_phase(15, 25, 25, 25, 1'b0);
		write_consult(6'd60);
		run_phase(40, 45, 45, 5, 1'b1);
		write_consult(6'd0);
		run_phase(20, 10, 15, 60, 1'b0);
		write_consult(6'd63);
		run_phase(12, 30, 30, 20, 1'b0);
		write_consult(CONSULT_W'($urandom_range(1, 60)));
		run_phase(10, 25, 25, 25, 1'b0);

		settle();
		repeat (4) @(posedge clk);
		if (room.mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
